[rtl/iirs_pkg.sv]
// Package for the integral image rectangle-sum core.
// Types, codes and sizes shared by the front end, back end and top level.
package iirs_pkg;
	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DIM_W = 9;
	localparam int CRD_W = 10;
	localparam int PIX_W = 16;
	localparam int RES_W = 32;
	localparam int ROWSUM_W = 24;
	localparam int AREA_W = 22;
	localparam int NUM_W = 40;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_PREFIX = 2'd1,
		OP_RECT = 2'd2,
		OP_MEAN = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_LOADED = 2'd2
	} status_t;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Classified command from the front end.
	typedef enum logic [2:0] {
		CMD_DONE = 3'b001,
		CMD_LOAD = 3'b010,
		CMD_QUERY = 3'b100
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic is_mean;
		status_t status;
		logic [PIX_W-1:0] pixel;
		logic [DIM_W-1:0] x0;
		logic [DIM_W-1:0] y0;
		logic [DIM_W-1:0] x1;
		logic [DIM_W-1:0] y1;
		logic [AREA_W-1:0] area;
	} cmd_pkt_t;
endpackage

[rtl/iirs_if.sv]
// Valid/ready channel interfaces for the integral image core.
// Depends on iirs_pkg for field widths.
interface iirs_in_if (input logic clk);
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [iirs_pkg::PIX_W-1:0] pixel_value;
	logic signed [iirs_pkg::CRD_W-1:0] col_a;
	logic signed [iirs_pkg::CRD_W-1:0] row_a;
	logic signed [iirs_pkg::CRD_W-1:0] col_b;
	logic signed [iirs_pkg::CRD_W-1:0] row_b;
	modport source (output valid, opcode, pixel_value, col_a, row_a, col_b, row_b,
		input ready);
	modport sink (input valid, opcode, pixel_value, col_a, row_a, col_b, row_b,
		output ready);
endinterface

interface iirs_out_if (input logic clk);
	logic valid;
	logic ready;
	logic [iirs_pkg::RES_W-1:0] result_value;
	logic [1:0] status;
	modport source (output valid, result_value, status, input ready);
	modport sink (input valid, result_value, status, output ready);
endinterface

[rtl/iirs_front.sv]
// Front end: accepts items, clamps and orders coordinates, tracks map validity.
// Depends on iirs_pkg. Feeds the command queue.
module iirs_front (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [iirs_pkg::DIM_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic [iirs_pkg::PIX_W-1:0] pixel_value,
	input logic signed [iirs_pkg::CRD_W-1:0] col_a,
	input logic signed [iirs_pkg::CRD_W-1:0] row_a,
	input logic signed [iirs_pkg::CRD_W-1:0] col_b,
	input logic signed [iirs_pkg::CRD_W-1:0] row_b,
	output logic push,
	input logic full,
	output iirs_pkg::cmd_pkt_t pkt,
	output logic [iirs_pkg::DIM_W-1:0] width,
	output logic [iirs_pkg::DIM_W-1:0] height
);
	logic [iirs_pkg::DIM_W-1:0] width_q, height_q;
	logic [iirs_pkg::DIM_W-1:0] lcol_q, lrow_q;
	logic valid_map_q;
	logic size_ok, load_ok, acc;
	logic signed [iirs_pkg::CRD_W:0] dw, dh;
	logic [iirs_pkg::DIM_W-1:0] cxa, cya, cxb, cyb;

	function automatic logic [iirs_pkg::DIM_W-1:0] clampc(
		input logic signed [iirs_pkg::CRD_W-1:0] v,
		input logic [iirs_pkg::DIM_W-1:0] hi);
		logic [iirs_pkg::DIM_W-1:0] r;
		if (v < 0) r = '0;
		else if ($unsigned(v) > {1'b0, hi}) r = hi;
		else r = v[iirs_pkg::DIM_W-1:0];
		return r;
	endfunction

	assign width = width_q;
	assign height = height_q;
	assign size_ok = (width_q != '0) && (height_q != '0)
		&& (width_q <= iirs_pkg::DIM_W'(iirs_pkg::MAX_WIDTH))
		&& (height_q <= iirs_pkg::DIM_W'(iirs_pkg::MAX_HEIGHT));
	assign in_ready = !full;
	assign acc = in_valid && !full;
	assign push = acc;
	assign load_ok = acc && (opcode == iirs_pkg::OP_LOAD) && size_ok;

	always_comb begin
		cxa = clampc(col_a, width_q);
		cxb = clampc(col_b, width_q);
		cya = clampc(row_a, height_q);
		cyb = clampc(row_b, height_q);
		dw = $signed({col_b[iirs_pkg::CRD_W-1], col_b})
			- $signed({col_a[iirs_pkg::CRD_W-1], col_a});
		dh = $signed({row_b[iirs_pkg::CRD_W-1], row_b})
			- $signed({row_a[iirs_pkg::CRD_W-1], row_a});
		pkt = '0;
		pkt.pixel = pixel_value;
		pkt.area = '0;
		pkt.cmd = iirs_pkg::CMD_DONE;
		pkt.status = iirs_pkg::ST_OK;
		unique case (opcode)
			iirs_pkg::OP_LOAD: begin
				if (!size_ok) pkt.status = iirs_pkg::ST_INVALID;
				else begin
					pkt.cmd = iirs_pkg::CMD_LOAD;
					pkt.status = iirs_pkg::ST_LOADED;
				end
			end
			iirs_pkg::OP_PREFIX: begin
				if (!valid_map_q) pkt.status = iirs_pkg::ST_INVALID;
				else begin
					// prefix = rect(0,0)-(x,y)
					pkt.cmd = iirs_pkg::CMD_QUERY;
					pkt.x1 = cxa;
					pkt.y1 = cya;
				end
			end
			default: begin
				if ((opcode == iirs_pkg::OP_MEAN) && ((dw <= 0) || (dh <= 0))) begin
					pkt.status = iirs_pkg::ST_OK;
				end else if (!valid_map_q) begin
					pkt.status = iirs_pkg::ST_INVALID;
				end else begin
					pkt.cmd = iirs_pkg::CMD_QUERY;
					pkt.is_mean = (opcode == iirs_pkg::OP_MEAN);
					pkt.x0 = (cxb < cxa) ? cxb : cxa;
					pkt.x1 = (cxb < cxa) ? cxa : cxb;
					pkt.y0 = (cyb < cya) ? cyb : cya;
					pkt.y1 = (cyb < cya) ? cya : cyb;
				end
			end
		endcase
		// only used by a mean with both differences positive, so 10 bits hold them
		pkt.area = iirs_pkg::AREA_W'({1'b0, dw[iirs_pkg::CRD_W-1:0]})
			* iirs_pkg::AREA_W'({1'b0, dh[iirs_pkg::CRD_W-1:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			height_q <= '0;
			lcol_q <= '0;
			lrow_q <= '0;
			valid_map_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == iirs_pkg::REG_WIDTH) width_q <= cfg_data;
			else height_q <= cfg_data;
			lcol_q <= '0;
			lrow_q <= '0;
			valid_map_q <= 1'b0;
		end else if (load_ok) begin
			if (lcol_q + 9'd1 >= width_q) begin
				lcol_q <= '0;
				if (lrow_q + 9'd1 >= height_q) begin
					lrow_q <= '0;
					valid_map_q <= 1'b1;
				end else begin
					lrow_q <= lrow_q + 9'd1;
					valid_map_q <= 1'b0;
				end
			end else begin
				lcol_q <= lcol_q + 9'd1;
				valid_map_q <= 1'b0;
			end
		end
	end
endmodule

[rtl/iirs_queue.sv]
// Two-entry command queue between front and back ends.
// Depends on iirs_pkg for the packet type.
module iirs_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input iirs_pkg::cmd_pkt_t wdata,
	output logic full,
	input logic pop,
	output logic empty,
	output iirs_pkg::cmd_pkt_t rdata
);
	iirs_pkg::cmd_pkt_t mem_q [iirs_pkg::QUEUE_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(iirs_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

[rtl/iirs_back.sv]
// Back end: builds the prefix table, reads four corners, optional Q.8 divide.
// Depends on iirs_pkg. Owns the prefix memory and the output register.
module iirs_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [iirs_pkg::DIM_W-1:0] width,
	input logic [iirs_pkg::DIM_W-1:0] height,
	input logic q_empty,
	input iirs_pkg::cmd_pkt_t pkt,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [iirs_pkg::RES_W-1:0] result_value,
	output logic [1:0] status
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LRD = 7'b0000010,
		S_LWR = 7'b0000100,
		S_QRD = 7'b0001000,
		S_QACC = 7'b0010000,
		S_DIV = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [iirs_pkg::RES_W-1:0] mem [iirs_pkg::MAX_WIDTH*iirs_pkg::MAX_HEIGHT];
	logic [iirs_pkg::RES_W-1:0] rd_q;
	logic [iirs_pkg::AW-1:0] raddr, waddr_q;
	logic rzero_q;
	logic [iirs_pkg::ROWSUM_W-1:0] rsum_q;
	logic [iirs_pkg::XW:0] lcol_q;
	logic [iirs_pkg::YW:0] lrow_q;
	logic built_q;
	iirs_pkg::cmd_pkt_t cur_q;
	logic [1:0] corner_q;
	logic [2:0] acc_cnt_q;
	logic [iirs_pkg::RES_W-1:0] sum_q;
	logic [iirs_pkg::NUM_W-1:0] rem_q;
	logic [iirs_pkg::NUM_W-1:0] quo_q;
	logic [5:0] bit_q;
	logic [iirs_pkg::RES_W-1:0] res_q;
	logic [1:0] st_q;
	logic [iirs_pkg::DIM_W-1:0] cx, cy;
	logic rd_zero;
	logic [iirs_pkg::NUM_W:0] trial;
	logic [iirs_pkg::NUM_W-1:0] rem_sh;
	logic [iirs_pkg::NUM_W-1:0] rem_nx;
	logic [iirs_pkg::NUM_W-1:0] quo_nx;
	logic [iirs_pkg::RES_W-1:0] acc_v;

	assign out_valid = (state_q == S_OUT);
	assign result_value = res_q;
	assign status = st_q;
	assign pop = (state_q == S_IDLE) && !q_empty;

	// corner order: (x1,y1) +, (x0,y1) -, (x1,y0) -, (x0,y0) +
	always_comb begin
		cx = corner_q[0] ? cur_q.x0 : cur_q.x1;
		cy = corner_q[1] ? cur_q.y0 : cur_q.y1;
		rd_zero = (cx == '0) || (cy == '0);
		raddr = {cy[iirs_pkg::YW-1:0] - iirs_pkg::YW'(1), cx[iirs_pkg::XW-1:0] - iirs_pkg::XW'(1)};
		if (state_q == S_LRD)
			raddr = {lrow_q[iirs_pkg::YW-1:0] - iirs_pkg::YW'(1), lcol_q[iirs_pkg::XW-1:0]};
		rem_sh = {rem_q[iirs_pkg::NUM_W-2:0], quo_q[iirs_pkg::NUM_W-1]};
		trial = {1'b0, rem_sh} - {19'd0, cur_q.area};
		rem_nx = trial[iirs_pkg::NUM_W] ? rem_sh : trial[iirs_pkg::NUM_W-1:0];
		quo_nx = {quo_q[iirs_pkg::NUM_W-2:0], !trial[iirs_pkg::NUM_W]};
		acc_v = rzero_q ? '0 : rd_q;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (state_q == S_LWR)
			mem[waddr_q] <= (rzero_q ? '0 : rd_q) + iirs_pkg::RES_W'(rsum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsum_q <= '0;
			lcol_q <= '0;
			lrow_q <= '0;
			built_q <= 1'b0;
			corner_q <= '0;
			acc_cnt_q <= '0;
			cur_q <= '0;
			sum_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= '0;
			res_q <= '0;
			st_q <= '0;
			rzero_q <= 1'b0;
			waddr_q <= '0;
		end else if (cfg_we) begin
			rsum_q <= '0;
			lcol_q <= '0;
			lrow_q <= '0;
			built_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cur_q <= pkt;
						st_q <= pkt.status;
						res_q <= '0;
						if (pkt.cmd == iirs_pkg::CMD_LOAD) begin
							if (built_q) begin
								rsum_q <= iirs_pkg::ROWSUM_W'(pkt.pixel);
								lcol_q <= '0;
								lrow_q <= '0;
								built_q <= 1'b0;
							end else begin
								rsum_q <= rsum_q + iirs_pkg::ROWSUM_W'(pkt.pixel);
							end
							state_q <= S_LRD;
						end else if (pkt.cmd == iirs_pkg::CMD_QUERY) begin
							corner_q <= '0;
							acc_cnt_q <= '0;
							sum_q <= '0;
							state_q <= S_QRD;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_LRD: begin
					rzero_q <= (lrow_q == '0);
					waddr_q <= {lrow_q[iirs_pkg::YW-1:0], lcol_q[iirs_pkg::XW-1:0]};
					state_q <= S_LWR;
				end
				S_LWR: begin
					if (lcol_q + 1'b1 >= {1'b0, width}) begin
						lcol_q <= '0;
						rsum_q <= '0;
						if (lrow_q + 1'b1 >= {1'b0, height}) begin
							lrow_q <= '0;
							built_q <= 1'b1;
						end else lrow_q <= lrow_q + 1'b1;
					end else lcol_q <= lcol_q + 1'b1;
					state_q <= S_OUT;
				end
				S_QRD: begin
					// read issued for corner_q; data lands next cycle
					rzero_q <= rd_zero;
					acc_cnt_q <= {1'b0, corner_q};
					corner_q <= corner_q + 2'd1;
					state_q <= S_QACC;
				end
				S_QACC: begin
					if (acc_cnt_q[1:0] == 2'd0 || acc_cnt_q[1:0] == 2'd3) sum_q <= sum_q + acc_v;
					else sum_q <= sum_q - acc_v;
					if (acc_cnt_q[1:0] == 2'd3) begin
						if (cur_q.is_mean) begin
							quo_q <= {sum_q + acc_v, 8'd0};
							rem_q <= '0;
							bit_q <= 6'(iirs_pkg::NUM_W);
							state_q <= S_DIV;
						end else begin
							res_q <= sum_q + acc_v;
							state_q <= S_OUT;
						end
					end else state_q <= S_QRD;
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd1) begin
						res_q <= quo_nx[iirs_pkg::RES_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/integral_image_rect_sum_core.sv]
// Integral image core: a load reads the entry above and writes one entry; queries
// make four serial reads of the prefix memory's one read port; means then run the
// 40-step restoring divider. One item in the back end at a time; a two-entry queue
// lets the front accept while a result waits. Reset clears sizes and the build
// state; the memory is not cleared and queries read it only after a full load.
module integral_image_rect_sum_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [iirs_pkg::DIM_W-1:0] cfg_data,
	iirs_in_if.sink in_ch,
	iirs_out_if.source out_ch
);
	logic push, full, pop, empty;
	iirs_pkg::cmd_pkt_t fpkt, qpkt;
	logic [iirs_pkg::DIM_W-1:0] width, height;

	iirs_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.opcode(in_ch.opcode), .pixel_value(in_ch.pixel_value),
		.col_a(in_ch.col_a), .row_a(in_ch.row_a),
		.col_b(in_ch.col_b), .row_b(in_ch.row_b),
		.push, .full, .pkt(fpkt), .width, .height
	);

	iirs_queue u_queue (
		.clk, .arst_n, .push, .wdata(fpkt), .full, .pop, .empty, .rdata(qpkt)
	);

	iirs_back u_back (
		.clk, .arst_n, .cfg_we, .width, .height,
		.q_empty(empty), .pkt(qpkt), .pop,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.result_value(out_ch.result_value), .status(out_ch.status)
	);
endmodule

[dv/integral_image_rect_sum_check.sv]
// Checker for the integral image core: tracks size writes and accepted input
// transactions, predicts each result and compares it. Depends on iirs_pkg, iirs_if.
module integral_image_rect_sum_check (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [iirs_pkg::DIM_W-1:0] cfg_data,
	iirs_in_if in_mon,
	iirs_out_if out_mon,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [iirs_pkg::RES_W-1:0] value;
		iirs_pkg::status_t status;
	} answer_t;

	answer_t answers[$];
	logic [iirs_pkg::RES_W-1:0] sat [0:iirs_pkg::MAX_WIDTH*iirs_pkg::MAX_HEIGHT-1];
	logic [iirs_pkg::DIM_W-1:0] img_w, img_h;
	logic [iirs_pkg::ROWSUM_W-1:0] run_sum;
	logic [iirs_pkg::DIM_W-1:0] fill_col, fill_row;
	logic map_ok;

	task automatic report(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic int clip(input int v, input int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [iirs_pkg::RES_W-1:0] prefix_at(input int x, input int y);
		if (x <= 0 || y <= 0) return '0;
		return sat[(y - 1) * iirs_pkg::MAX_WIDTH + x - 1];
	endfunction

	function automatic logic [iirs_pkg::RES_W-1:0] box_sum(input int x0, input int y0,
			input int x1, input int y1);
		int t;
		x0 = clip(x0, int'(img_w)); x1 = clip(x1, int'(img_w));
		y0 = clip(y0, int'(img_h)); y1 = clip(y1, int'(img_h));
		if (x1 < x0) begin t = x0; x0 = x1; x1 = t; end
		if (y1 < y0) begin t = y0; y0 = y1; y1 = t; end
		return prefix_at(x1, y1) - prefix_at(x0, y1) - prefix_at(x1, y0) + prefix_at(x0, y0);
	endfunction

	function automatic void restart_build();
		map_ok = 1'b0;
		run_sum = '0;
		fill_col = '0;
		fill_row = '0;
	endfunction

	function automatic answer_t predict_answer(input iirs_pkg::opcode_t op,
			input logic [iirs_pkg::PIX_W-1:0] pix,
			input int xa, input int ya, input int xb, input int yb);
		answer_t a;
		int idx, w, h;
		logic [iirs_pkg::RES_W-1:0] above;
		logic [63:0] area, num;
		a.value = '0;
		a.status = iirs_pkg::ST_OK;
		case (op)
			iirs_pkg::OP_LOAD: begin
				if (img_w == 0 || img_h == 0 || img_w > iirs_pkg::MAX_WIDTH
						|| img_h > iirs_pkg::MAX_HEIGHT) begin
					a.status = iirs_pkg::ST_INVALID;
				end else begin
					if (map_ok) restart_build();
					run_sum = run_sum + iirs_pkg::ROWSUM_W'(pix);
					idx = int'(fill_row) * iirs_pkg::MAX_WIDTH + int'(fill_col);
					above = (fill_row == 0) ? '0 : sat[idx - iirs_pkg::MAX_WIDTH];
					sat[idx] = above + iirs_pkg::RES_W'(run_sum);
					fill_col++;
					if (fill_col >= img_w) begin
						fill_col = '0;
						run_sum = '0;
						fill_row++;
						if (fill_row >= img_h) begin
							fill_row = '0;
							map_ok = 1'b1;
						end
					end
					a.status = iirs_pkg::ST_LOADED;
				end
			end
			iirs_pkg::OP_PREFIX: begin
				if (!map_ok) a.status = iirs_pkg::ST_INVALID;
				else a.value = prefix_at(clip(xa, int'(img_w)), clip(ya, int'(img_h)));
			end
			iirs_pkg::OP_RECT: begin
				if (!map_ok) a.status = iirs_pkg::ST_INVALID;
				else a.value = box_sum(xa, ya, xb, yb);
			end
			default: begin
				// mean: area from unclamped corners; empty area is 0/ok even when invalid
				w = (xb > xa) ? xb - xa : 0;
				h = (yb > ya) ? yb - ya : 0;
				if (w != 0 && h != 0) begin
					if (!map_ok) begin
						a.status = iirs_pkg::ST_INVALID;
					end else begin
						area = 64'(w) * 64'(h);
						num = {32'd0, box_sum(xa, ya, xb, yb)} << 8;
						a.value = iirs_pkg::RES_W'(num / area);
					end
				end
			end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			answers.delete();
			errors = 0;
			img_w = '0;
			img_h = '0;
			restart_build();
		end else begin
			if (cfg_we) begin
				if (cfg_index == iirs_pkg::REG_WIDTH) img_w = cfg_data;
				else img_h = cfg_data;
				restart_build();
			end
			if (in_mon.valid && in_mon.ready)
				answers.push_back(predict_answer(iirs_pkg::opcode_t'(in_mon.opcode),
					in_mon.pixel_value,
					int'(in_mon.col_a), int'(in_mon.row_a),
					int'(in_mon.col_b), int'(in_mon.row_b)));
			if (out_mon.valid && out_mon.ready) begin
				if (answers.size() == 0) begin
					report($sformatf("unexpected result value=%0h status=%0d",
						out_mon.result_value, out_mon.status));
				end else begin
					want = answers.pop_front();
					if (out_mon.result_value !== want.value)
						report($sformatf("result_value %0h, want %0h",
							out_mon.result_value, want.value));
					if (out_mon.status !== want.status)
						report($sformatf("status %0d, want %0d", out_mon.status, want.status));
				end
			end
		end
		pending = answers.size();
	end
endmodule

[dv/integral_image_rect_sum_core_test.sv]
// Top of the integral image core testbench: clock, reset, size writes, stimulus
// and verdict. Depends on iirs_pkg, iirs_if, the core and integral_image_rect_sum_check.
module integral_image_rect_sum_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = iirs_pkg::REG_WIDTH;
	logic [iirs_pkg::DIM_W-1:0] cfg_data = '0;
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	int errors, pending, sent, cycles;
	int cur_w, cur_h;

	iirs_in_if in_ch (clk);
	iirs_out_if out_ch (clk);

	integral_image_rect_sum_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	integral_image_rect_sum_check chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_mon(in_ch), .out_mon(out_ch),
		.errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		int held;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				for (held = 0; held < 300; held++) @(posedge clk);
				hold_req <= 1'b0;
				@(posedge clk);
			end
			out_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
		end
	end

	task automatic send(input iirs_pkg::opcode_t op, input logic [iirs_pkg::PIX_W-1:0] pix,
			input int ca, input int ra, input int cb, input int rb);
		int gap;
		if (!calm && $urandom_range(0, 99) < 14) begin
			in_ch.valid <= 1'b0;
			for (gap = $urandom_range(1, 4); gap > 0; gap--) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.pixel_value <= pix;
		in_ch.col_a <= ca[iirs_pkg::CRD_W-1:0];
		in_ch.row_a <= ra[iirs_pkg::CRD_W-1:0];
		in_ch.col_b <= cb[iirs_pkg::CRD_W-1:0];
		in_ch.row_b <= rb[iirs_pkg::CRD_W-1:0];
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	task automatic set_size(input int w, input int h);
		in_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= iirs_pkg::REG_WIDTH;
		cfg_data <= w[iirs_pkg::DIM_W-1:0];
		@(posedge clk);
		cfg_index <= iirs_pkg::REG_HEIGHT;
		cfg_data <= h[iirs_pkg::DIM_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_w = w;
		cur_h = h;
	endtask

	function automatic int pick_coord(input int lim);
		if ($urandom_range(0, 99) < 80) return int'($urandom_range(0, lim + 4)) - 2;
		return int'($urandom_range(0, 1023)) - 512;
	endfunction

	task automatic load_image(input int count);
		int n;
		for (n = 0; n < count; n++)
			send(iirs_pkg::OP_LOAD, iirs_pkg::PIX_W'($urandom), 0, 0, 0, 0);
	endtask

	task automatic random_query();
		iirs_pkg::opcode_t op;
		op = iirs_pkg::opcode_t'($urandom_range(1, 3));
		send(op, iirs_pkg::PIX_W'($urandom), pick_coord(cur_w), pick_coord(cur_h),
			pick_coord(cur_w), pick_coord(cur_h));
	endtask

	initial begin
		int n, w, h, n_px;
		in_ch.valid = 1'b0;
		in_ch.opcode = iirs_pkg::OP_LOAD;
		in_ch.pixel_value = '0;
		in_ch.col_a = '0;
		in_ch.row_a = '0;
		in_ch.col_b = '0;
		in_ch.row_b = '0;
		sent = 0;
		cycles = 0;
		cur_w = 0;
		cur_h = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no size yet: everything invalid except an empty mean
		send(iirs_pkg::OP_PREFIX, 0, 1, 1, 0, 0);
		send(iirs_pkg::OP_LOAD, 16'hffff, 0, 0, 0, 0);
		send(iirs_pkg::OP_MEAN, 0, 3, 3, 1, 5);
		send(iirs_pkg::OP_MEAN, 0, 0, 0, 2, 2);
		send(iirs_pkg::OP_RECT, 0, 0, 0, 1, 1);

		set_size(3, 2);
		send(iirs_pkg::OP_LOAD, 16'hffff, 0, 0, 0, 0);
		send(iirs_pkg::OP_LOAD, 16'h0000, 0, 0, 0, 0);
		send(iirs_pkg::OP_RECT, 0, 0, 0, 3, 2);
		load_image(4);
		send(iirs_pkg::OP_PREFIX, 0, -512, 511, 0, 0);
		send(iirs_pkg::OP_PREFIX, 0, 511, 511, 0, 0);
		send(iirs_pkg::OP_PREFIX, 0, 2, 1, 0, 0);
		send(iirs_pkg::OP_RECT, 0, 511, 511, -512, -512);
		send(iirs_pkg::OP_RECT, 0, 3, 2, 1, 0);
		send(iirs_pkg::OP_MEAN, 0, 0, 0, 3, 2);
		send(iirs_pkg::OP_MEAN, 0, -512, -512, 511, 511);
		send(iirs_pkg::OP_MEAN, 0, 2, 0, 1, 2);
		send(iirs_pkg::OP_MEAN, 0, 1, 1, 1, 2);
		send(iirs_pkg::OP_LOAD, 16'h5a5a, 0, 0, 0, 0);
		send(iirs_pkg::OP_PREFIX, 0, 3, 2, 0, 0);

		// long receiver hold-off while loads keep coming: input stalls
		set_size(256, 1);
		hold_req <= 1'b1;
		load_image(256);
		send(iirs_pkg::OP_RECT, 0, 0, 0, 256, 1);
		send(iirs_pkg::OP_MEAN, 0, 0, 0, 256, 1);
		// long stretch with no idling on either side
		calm <= 1'b1;
		set_size(1, 256);
		load_image(256);
		send(iirs_pkg::OP_PREFIX, 0, 1, 256, 0, 0);
		send(iirs_pkg::OP_MEAN, 0, -3, -7, 2, 300);
		calm <= 1'b0;
		set_size(511, 4);
		send(iirs_pkg::OP_LOAD, 1, 0, 0, 0, 0);
		set_size(4, 257);
		send(iirs_pkg::OP_LOAD, 1, 0, 0, 0, 0);
		send(iirs_pkg::OP_PREFIX, 0, 1, 1, 0, 0);

		while (sent < 550) begin
			case ($urandom_range(0, 9))
				0: begin
					w = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(257, 511);
					h = $urandom_range(0, 511);
				end
				1: begin w = $urandom_range(1, 32); h = $urandom_range(1, 4); end
				default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
			endcase
			set_size(w, h);
			// an unusable size only sees a few rejected loads
			n_px = (w >= 1 && w <= iirs_pkg::MAX_WIDTH && h >= 1
				&& h <= iirs_pkg::MAX_HEIGHT) ? w * h : 3;
			if ($urandom_range(0, 9) == 0) begin
				// possibly broken build: part or all of an image, then queries on the map as it stands
				load_image($urandom_range(0, n_px));
				for (n = 0; n < 4; n++) random_query();
			end
			load_image(n_px);
			for (n = $urandom_range(15, 30); n > 0; n--) begin
				if ($urandom_range(0, 29) == 0)
					send(iirs_pkg::OP_LOAD, iirs_pkg::PIX_W'($urandom), 0, 0, 0, 0);
				else random_query();
			end
		end
		calm <= 1'b0;
		in_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

[files.f]
rtl/iirs_pkg.sv
rtl/iirs_if.sv
rtl/iirs_front.sv
rtl/iirs_queue.sv
rtl/iirs_back.sv
rtl/integral_image_rect_sum_core.sv
dv/integral_image_rect_sum_check.sv
dv/integral_image_rect_sum_core_test.sv
